/* rtl/ircfd_pkg.sv */
// Shared types and constants of the infrared climate frame decoder.
package ircfd_pkg;

   localparam int NOM_BITS    = 16;
   localparam int TOL_BITS    = 7;
   localparam int PROD_BITS   = 24;
   localparam int NUM_WINDOWS = 5;
   localparam int CSR_ADDR_BITS = 3;

   localparam int DATA_BITS  = 35;
   localparam int POS_BITS   = 6;
   localparam logic [POS_BITS-1:0] LAST_POS  = POS_BITS'(DATA_BITS - 1);
   localparam logic [POS_BITS-1:0] RSV_FIRST = 6'd12;
   localparam logic [POS_BITS-1:0] RSV_LAST  = 6'd19;

   localparam logic [10:0] CONTROL_WORD = 11'h250;
   localparam logic [TOL_BITS-1:0] TOL_MAX = 7'd100;
   localparam logic [7:0] PERCENT_FULL = 8'd100;

   localparam logic [NOM_BITS-1:0] HDR_MARK_RESET  = 16'd9000;
   localparam logic [NOM_BITS-1:0] HDR_SPACE_RESET = 16'd4500;
   localparam logic [NOM_BITS-1:0] BIT_MARK_RESET  = 16'd650;
   localparam logic [NOM_BITS-1:0] ONE_SPACE_RESET = 16'd1650;
   localparam logic [NOM_BITS-1:0] ZERO_SPACE_RESET = 16'd550;
   localparam logic [TOL_BITS-1:0] TOL_RESET       = 7'd25;

   localparam int RSP_DATA_BITS = 24;

   // Register indexes of the configuration port; the five nominal indexes also index the window table.
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_HDR_MARK   = 3'd0,
      REG_HDR_SPACE  = 3'd1,
      REG_BIT_MARK   = 3'd2,
      REG_ONE_SPACE  = 3'd3,
      REG_ZERO_SPACE = 3'd4,
      REG_TOLERANCE  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK            = 3'd0,
      ST_BAD_HEADER    = 3'd1,
      ST_BAD_PULSE     = 3'd2,
      ST_RSV_SET       = 3'd3,
      ST_CTRL_MISMATCH = 3'd4
   } status_type;

   // Result item, last field in the lowest bits.
   typedef struct packed {
      logic       blow_on;
      logic       tree_icon_on;
      logic       light_on;
      logic       turbo_on;
      logic [3:0] temp_offset;
      logic       sleep_on;
      logic       swing_on;
      logic [1:0] fan_code;
      logic       power_on;
      logic [2:0] mode_code;
      status_type status;
   } result_type;

endpackage

/* rtl/ircfd_window.sv */
// Tolerance window check of one measured duration against precomputed bounds.
module ircfd_window #(
   parameter int DUR_BITS = 16
) (
   input  logic [DUR_BITS-1:0]            dur,
   input  logic [ircfd_pkg::PROD_BITS-1:0] lo_prod,
   input  logic [ircfd_pkg::PROD_BITS-1:0] hi_prod,
   output logic                           match
);
   import ircfd_pkg::*;

   localparam int CMP_BITS = (DUR_BITS + 7 > PROD_BITS) ? DUR_BITS + 7 : PROD_BITS;

   logic [CMP_BITS-1:0] dur_ext;
   logic [CMP_BITS-1:0] dur_x100;
   logic                lo_ok;
   logic                hi_ok;

   // floor(P/100) <= d  is  P <= 100*d + 99;  d <= floor(Q/100)  is  100*d <= Q.
   assign dur_ext  = CMP_BITS'(dur);
   assign dur_x100 = (dur_ext << 6) + (dur_ext << 5) + (dur_ext << 2);
   assign lo_ok    = CMP_BITS'(lo_prod) <= (dur_x100 + CMP_BITS'(99));
   assign hi_ok    = dur_x100 <= CMP_BITS'(hi_prod);
   assign match    = lo_ok && hi_ok;

endmodule

/* rtl/ir_climate_frame_decoder.sv */
// Top level of the infrared climate frame decoder.
//
//  Channel | Direction | Handshake            | Contents
//  req     | in        | req_tvalid/tready    | one mark/space pair, frame start in tuser
//  rsp     | out       | rsp_tvalid/tready    | status and decoded frame fields
//  csr     | in        | csr_we               | timing nominals and tolerance, write only
//
// One pair is taken every cycle while no result waits untaken. A pair lands in an input
// register at its transfer, is classified while it is held there, and any result is loaded
// into the output register when the pair leaves it. The window bounds are registered
// products of the configuration, so a write passes through the configuration and product registers.
// Reset (synchronous, active high) restores the default timing and drops any frame.
// While a result waits untaken, the pair in the input register waits too and req stalls.
module ir_climate_frame_decoder #(
   parameter int DURATION_BITS = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0: mark_us, space_us, zero padding.
   input  logic [((2*DURATION_BITS+7)/8)*8-1:0]       req_tdata,
   // Fields: frame_start.
   input  logic                                       req_tuser,

   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // Fields from bit 0: status, mode_code, power_on, fan_code, swing_on, sleep_on,
   // temp_offset, turbo_on, light_on, tree_icon_on, blow_on, zero padding.
   output logic [ircfd_pkg::RSP_DATA_BITS-1:0]        rsp_tdata,

   input  logic                                       csr_we,
   input  logic [ircfd_pkg::CSR_ADDR_BITS-1:0]        csr_addr,
   input  logic [ircfd_pkg::NOM_BITS-1:0]             csr_wdata
);
   import ircfd_pkg::*;

   localparam int DB = DURATION_BITS;

   // Configuration registers; nominals are indexed by their register index.
   logic [NOM_BITS-1:0]  nom_ff [NUM_WINDOWS];
   logic [NOM_BITS-1:0]  nom_in [NUM_WINDOWS];
   logic [TOL_BITS-1:0]  tol_ff;
   logic [TOL_BITS-1:0]  tol_in;

   // Window bounds as n*(100-t) and n*(100+t), compared against 100*d.
   logic [TOL_BITS-1:0]  tol_eff;
   logic [7:0]           lo_fac;
   logic [7:0]           hi_fac;
   logic [PROD_BITS-1:0] lo_prod_ff [NUM_WINDOWS];
   logic [PROD_BITS-1:0] hi_prod_ff [NUM_WINDOWS];
   logic [PROD_BITS-1:0] lo_prod_in [NUM_WINDOWS];
   logic [PROD_BITS-1:0] hi_prod_in [NUM_WINDOWS];

   // Input register.
   logic          in_valid_ff, in_valid_in;
   logic          in_start_ff;
   logic [DB-1:0] in_mark_ff, in_space_ff;
   logic          req_xfer;
   logic          advance;

   // Frame state. The header always precedes the data bits, so one flag tracks
   // both an active frame and a seen header.
   logic                  active_ff, active_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [DATA_BITS-1:0]  acc_ff, acc_in;
   logic [DATA_BITS-1:0]  acc_set;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;
   logic       emit;
   result_type result;

   // Window matches.
   logic hmark_match, hspace_match, bmark_match, one_match, zero_match;
   logic hdr_ok, is_one, is_zero, reserved;

   // ---------------- configuration ----------------
   always_comb begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
         nom_in[i] = nom_ff[i];
      end
      tol_in = tol_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_HDR_MARK:   nom_in[REG_HDR_MARK]   = csr_wdata;
            REG_HDR_SPACE:  nom_in[REG_HDR_SPACE]  = csr_wdata;
            REG_BIT_MARK:   nom_in[REG_BIT_MARK]   = csr_wdata;
            REG_ONE_SPACE:  nom_in[REG_ONE_SPACE]  = csr_wdata;
            REG_ZERO_SPACE: nom_in[REG_ZERO_SPACE] = csr_wdata;
            REG_TOLERANCE:  tol_in = csr_wdata[TOL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nom_ff[REG_HDR_MARK]   <= HDR_MARK_RESET;
         nom_ff[REG_HDR_SPACE]  <= HDR_SPACE_RESET;
         nom_ff[REG_BIT_MARK]   <= BIT_MARK_RESET;
         nom_ff[REG_ONE_SPACE]  <= ONE_SPACE_RESET;
         nom_ff[REG_ZERO_SPACE] <= ZERO_SPACE_RESET;
         tol_ff                 <= TOL_RESET;
      end else begin
         for (int i = 0; i < NUM_WINDOWS; i++) begin
            nom_ff[i] <= nom_in[i];
         end
         tol_ff <= tol_in;
      end
   end

   // A tolerance above 100 percent behaves as 100, which opens the lower bound to zero.
   assign tol_eff = (tol_ff > TOL_MAX) ? TOL_MAX : tol_ff;
   assign lo_fac  = PERCENT_FULL - 8'(tol_eff);
   assign hi_fac  = PERCENT_FULL + 8'(tol_eff);

   always_comb begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
         lo_prod_in[i] = PROD_BITS'(nom_ff[i]) * PROD_BITS'(lo_fac);
         hi_prod_in[i] = PROD_BITS'(nom_ff[i]) * PROD_BITS'(hi_fac);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_WINDOWS; i++) begin
         lo_prod_ff[i] <= lo_prod_in[i];
         hi_prod_ff[i] <= hi_prod_in[i];
      end
   end

   // ---------------- input register ----------------
   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_xfer    = req_tvalid && req_tready;
   assign in_valid_in = req_xfer || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_start_ff <= req_tuser;
         in_mark_ff  <= req_tdata[DB-1:0];
         in_space_ff <= req_tdata[2*DB-1:DB];
      end
   end

   // ---------------- pair classification ----------------
   ircfd_window #(.DUR_BITS(DB)) u_hmark (
      .dur(in_mark_ff), .lo_prod(lo_prod_ff[REG_HDR_MARK]),
      .hi_prod(hi_prod_ff[REG_HDR_MARK]), .match(hmark_match));
   ircfd_window #(.DUR_BITS(DB)) u_hspace (
      .dur(in_space_ff), .lo_prod(lo_prod_ff[REG_HDR_SPACE]),
      .hi_prod(hi_prod_ff[REG_HDR_SPACE]), .match(hspace_match));
   ircfd_window #(.DUR_BITS(DB)) u_bmark (
      .dur(in_mark_ff), .lo_prod(lo_prod_ff[REG_BIT_MARK]),
      .hi_prod(hi_prod_ff[REG_BIT_MARK]), .match(bmark_match));
   ircfd_window #(.DUR_BITS(DB)) u_one (
      .dur(in_space_ff), .lo_prod(lo_prod_ff[REG_ONE_SPACE]),
      .hi_prod(hi_prod_ff[REG_ONE_SPACE]), .match(one_match));
   ircfd_window #(.DUR_BITS(DB)) u_zero (
      .dur(in_space_ff), .lo_prod(lo_prod_ff[REG_ZERO_SPACE]),
      .hi_prod(hi_prod_ff[REG_ZERO_SPACE]), .match(zero_match));

   assign hdr_ok   = hmark_match && hspace_match;
   assign is_one   = bmark_match && one_match;
   assign is_zero  = bmark_match && zero_match;
   assign reserved = (pos_ff >= RSV_FIRST) && (pos_ff <= RSV_LAST);

   always_comb begin
      acc_set         = acc_ff;
      acc_set[pos_ff] = 1'b1;
   end

   // ---------------- frame sequencing ----------------
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      emit      = 1'b0;
      result    = '0;
      result.status = ST_OK;

      if (advance) begin
         if (in_start_ff) begin
            // A start always drops a partial frame silently and opens a fresh one if the header matches.
            active_in = hdr_ok;
            pos_in    = '0;
            acc_in    = '0;
            if (!hdr_ok) begin
               emit          = 1'b1;
               result.status = ST_BAD_HEADER;
            end
         end else if (active_ff) begin
            if (reserved && !is_zero) begin
               // Reserved bits must read as zero; a clean one is a distinct failure.
               emit          = 1'b1;
               result.status = is_one ? ST_RSV_SET : ST_BAD_PULSE;
            end else if (!reserved && !is_one && !is_zero) begin
               emit          = 1'b1;
               result.status = ST_BAD_PULSE;
            end else begin
               // A pair that fits both spaces counts as a one outside the reserved span.
               acc_in = (is_one && !reserved) ? acc_set : acc_ff;
               pos_in = pos_ff + 1'b1;
               if (pos_ff == LAST_POS) begin
                  emit = 1'b1;
                  if (acc_in[34:24] == CONTROL_WORD) begin
                     result.status       = ST_OK;
                     result.mode_code    = acc_in[2:0];
                     result.power_on     = acc_in[3];
                     result.fan_code     = acc_in[5:4];
                     result.swing_on     = acc_in[6];
                     result.sleep_on     = acc_in[7];
                     result.temp_offset  = acc_in[11:8];
                     result.turbo_on     = acc_in[20];
                     result.light_on     = acc_in[21];
                     result.tree_icon_on = acc_in[22];
                     result.blow_on      = acc_in[23];
                  end else begin
                     result.status = ST_CTRL_MISMATCH;
                  end
               end
            end
            // Every result ends the frame and clears its state.
            if (emit) begin
               active_in = 1'b0;
               pos_in    = '0;
               acc_in    = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
         acc_ff    <= acc_in;
      end
   end

   // ---------------- output register ----------------
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_tready);
   assign rsp_in       = emit ? result : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_ff);

endmodule

/* dv/ircfd_frame_checker.sv */
// Checker for the infrared climate frame decoder: predicts every result and compares it.
`timescale 1ns / 1ps

module ircfd_frame_checker (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   input  logic                                  req_tready,
   input  logic [31:0]                           req_tdata,
   input  logic                                  req_tuser,

   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic [ircfd_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,

   input  logic                                  csr_we,
   input  logic [ircfd_pkg::CSR_ADDR_BITS-1:0]   csr_addr,
   input  logic [ircfd_pkg::NOM_BITS-1:0]        csr_wdata,

   output int                                    mismatch_count,
   output int                                    frames_outstanding
);
   import ircfd_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int FIELD_BITS   = $bits(result_type);

   // Timing configuration as the decoder should hold it.
   logic [NOM_BITS-1:0]  hdr_mark_nom;
   logic [NOM_BITS-1:0]  hdr_space_nom;
   logic [NOM_BITS-1:0]  bit_mark_nom;
   logic [NOM_BITS-1:0]  one_space_nom;
   logic [NOM_BITS-1:0]  zero_space_nom;
   logic [TOL_BITS-1:0]  tol_pct;

   // Frame being gathered.
   logic                 in_frame;
   logic                 header_ok;
   logic [POS_BITS-1:0]  bit_pos;
   logic [DATA_BITS-1:0] frame_bits;

   result_type           expected_frames[$];
   result_type           got_frame;
   result_type           want_frame;
   result_type           new_frame;

   initial begin
      mismatch_count     = 0;
      frames_outstanding = 0;
   end

   function automatic bit duration_fits(logic [NOM_BITS-1:0] d, logic [NOM_BITS-1:0] nom);
      int unsigned t;
      int unsigned lo;
      int unsigned hi;
      t  = (tol_pct > TOL_MAX) ? 100 : tol_pct;
      lo = (int'(nom) * (100 - t)) / 100;
      hi = (int'(nom) * (100 + t)) / 100;
      return (d >= lo) && (d <= hi);
   endfunction

   function automatic void drop_frame();
      in_frame   = 1'b0;
      header_ok  = 1'b0;
      bit_pos    = '0;
      frame_bits = '0;
   endfunction

   // Advances the frame state by one mark/space pair; returns 1 when a result is due.
   function automatic bit decode_pair(input logic start, input logic [NOM_BITS-1:0] mark,
                                      input logic [NOM_BITS-1:0] space,
                                      output result_type frame);
      logic mark_ok;
      logic is_one;
      logic is_zero;
      frame = '0;
      if (start) begin
         drop_frame();
         if (duration_fits(mark, hdr_mark_nom) && duration_fits(space, hdr_space_nom)) begin
            in_frame  = 1'b1;
            header_ok = 1'b1;
            return 1'b0;
         end
         frame.status = ST_BAD_HEADER;
         return 1'b1;
      end
      if (!in_frame || !header_ok) return 1'b0;

      mark_ok = duration_fits(mark, bit_mark_nom);
      is_one  = mark_ok && duration_fits(space, one_space_nom);
      is_zero = mark_ok && duration_fits(space, zero_space_nom);

      if (bit_pos >= RSV_FIRST && bit_pos <= RSV_LAST) begin
         // Reserved bits must be zeros; a clean one pulse there has its own status.
         if (!is_zero) begin
            frame.status = is_one ? ST_RSV_SET : ST_BAD_PULSE;
            drop_frame();
            return 1'b1;
         end
      end else if (is_one) begin
         frame_bits[bit_pos] = 1'b1;
      end else if (!is_zero) begin
         frame.status = ST_BAD_PULSE;
         drop_frame();
         return 1'b1;
      end

      bit_pos = bit_pos + 1'b1;
      if (bit_pos != DATA_BITS) return 1'b0;

      if (frame_bits[DATA_BITS-1 -: 11] != CONTROL_WORD) begin
         frame.status = ST_CTRL_MISMATCH;
      end else begin
         frame.status       = ST_OK;
         frame.mode_code    = frame_bits[2:0];
         frame.power_on     = frame_bits[3];
         frame.fan_code     = frame_bits[5:4];
         frame.swing_on     = frame_bits[6];
         frame.sleep_on     = frame_bits[7];
         frame.temp_offset  = frame_bits[11:8];
         frame.turbo_on     = frame_bits[20];
         frame.light_on     = frame_bits[21];
         frame.tree_icon_on = frame_bits[22];
         frame.blow_on      = frame_bits[23];
      end
      drop_frame();
      return 1'b1;
   endfunction

   function automatic string show_frame(result_type f);
      return $sformatf({"status %0d mode %0d power %0d fan %0d swing %0d sleep %0d",
                        " temp %0d turbo %0d light %0d tree %0d blow %0d"},
                       f.status, f.mode_code, f.power_on, f.fan_code, f.swing_on, f.sleep_on,
                       f.temp_offset, f.turbo_on, f.light_on, f.tree_icon_on, f.blow_on);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         hdr_mark_nom   = HDR_MARK_RESET;
         hdr_space_nom  = HDR_SPACE_RESET;
         bit_mark_nom   = BIT_MARK_RESET;
         one_space_nom  = ONE_SPACE_RESET;
         zero_space_nom = ZERO_SPACE_RESET;
         tol_pct        = TOL_RESET;
         drop_frame();
         expected_frames.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_HDR_MARK:   hdr_mark_nom   = csr_wdata;
               REG_HDR_SPACE:  hdr_space_nom  = csr_wdata;
               REG_BIT_MARK:   bit_mark_nom   = csr_wdata;
               REG_ONE_SPACE:  one_space_nom  = csr_wdata;
               REG_ZERO_SPACE: zero_space_nom = csr_wdata;
               REG_TOLERANCE:  tol_pct        = csr_wdata[TOL_BITS-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            if (decode_pair(req_tuser, req_tdata[15:0], req_tdata[31:16], new_frame))
               expected_frames.push_back(new_frame);
         end

         if (rsp_tvalid && rsp_tready) begin
            got_frame = result_type'(rsp_tdata[FIELD_BITS-1:0]);
            if (expected_frames.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result with none pending: %s", $realtime, show_frame(got_frame));
            end else begin
               want_frame = expected_frames.pop_front();
               if (got_frame.status       !== want_frame.status       ||
                   got_frame.mode_code    !== want_frame.mode_code    ||
                   got_frame.power_on     !== want_frame.power_on     ||
                   got_frame.fan_code     !== want_frame.fan_code     ||
                   got_frame.swing_on     !== want_frame.swing_on     ||
                   got_frame.sleep_on     !== want_frame.sleep_on     ||
                   got_frame.temp_offset  !== want_frame.temp_offset  ||
                   got_frame.turbo_on     !== want_frame.turbo_on     ||
                   got_frame.light_on     !== want_frame.light_on     ||
                   got_frame.tree_icon_on !== want_frame.tree_icon_on ||
                   got_frame.blow_on      !== want_frame.blow_on      ||
                   rsp_tdata[RSP_DATA_BITS-1:FIELD_BITS] !== '0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", show_frame(want_frame));
                     $display("   actual   %s pad %h", show_frame(got_frame),
                              rsp_tdata[RSP_DATA_BITS-1:FIELD_BITS]);
                  end
               end
            end
         end
      end
      frames_outstanding <= expected_frames.size();
   end

endmodule

/* dv/tb_top.sv */
// Top of the decoder testbench: clock, reset, stimulus, checker hookup and verdict.
`timescale 1ns / 1ps

module tb_top;
   import ircfd_pkg::*;

   localparam int ITEM_TARGET   = 1700;
   localparam int PHASE_COUNT   = 10;
   localparam int CALM_PHASE    = 7;
   localparam int IDLE_PERCENT  = 19;
   // A pair reaches the result register through the input register; the settle wait
   // also covers pairs that produce nothing and the registered window bounds.
   localparam int SETTLE_CYCLES = 6;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int DUR_TOP       = 65535;

   // Register indexes that map to nothing; writes to them must leave the timing alone.
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_INDEX_LO = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_INDEX_HI = 3'd7;

   typedef enum int {
      FLAW_NONE,
      FLAW_HEADER,
      FLAW_PULSE,
      FLAW_RESERVED,
      FLAW_CONTROL,
      FLAW_CUT
   } frame_flaw_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [31:0]               req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_addr   = '0;
   logic [NOM_BITS-1:0]       csr_wdata  = '0;

   int                        mismatch_count;
   int                        frames_outstanding;

   // When set, neither side idles: one whole phase runs at full rate.
   bit                        calm_mode = 1'b0;
   // Pairs that the decoder acts on; ignored pairs are not counted.
   int                        counted_items = 0;

   // Copy of the timing that the stimulus was written with, used only to shape
   // durations that land inside or outside the windows.
   logic [NOM_BITS-1:0]       cfg_hdr_mark   = HDR_MARK_RESET;
   logic [NOM_BITS-1:0]       cfg_hdr_space  = HDR_SPACE_RESET;
   logic [NOM_BITS-1:0]       cfg_bit_mark   = BIT_MARK_RESET;
   logic [NOM_BITS-1:0]       cfg_one_space  = ONE_SPACE_RESET;
   logic [NOM_BITS-1:0]       cfg_zero_space = ZERO_SPACE_RESET;
   logic [TOL_BITS-1:0]       cfg_tol        = TOL_RESET;

   always #2 clock = ~clock;

   ir_climate_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   ircfd_frame_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .csr_we             (csr_we),
      .csr_addr           (csr_addr),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .frames_outstanding (frames_outstanding)
   );

   // The result side stalls at random, except during the calm phase.
   always @(negedge clock) begin
      rsp_tready <= calm_mode || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Bounds of the window around a nominal duration, clipped to the field range.
   function automatic void window_of(input logic [NOM_BITS-1:0] nom,
                                     output int unsigned lo, output int unsigned hi);
      int unsigned t;
      t  = (cfg_tol > TOL_MAX) ? 100 : cfg_tol;
      lo = (int'(nom) * (100 - t)) / 100;
      hi = (int'(nom) * (100 + t)) / 100;
      if (hi > DUR_TOP) hi = DUR_TOP;
   endfunction

   // A duration inside the window, often right on one of its edges.
   function automatic logic [NOM_BITS-1:0] pick_inside(input logic [NOM_BITS-1:0] nom);
      int unsigned lo;
      int unsigned hi;
      window_of(nom, lo, hi);
      case ($urandom_range(7))
         0: return NOM_BITS'(lo);
         1: return NOM_BITS'(hi);
         default: return NOM_BITS'($urandom_range(hi, lo));
      endcase
   endfunction

   // A duration outside the window, often just past an edge. When the window
   // spans the whole range nothing lies outside, and any value is returned.
   function automatic logic [NOM_BITS-1:0] pick_outside(input logic [NOM_BITS-1:0] nom);
      int unsigned lo;
      int unsigned hi;
      window_of(nom, lo, hi);
      if (lo > 0 && (hi == DUR_TOP || $urandom_range(1) == 1))
         return NOM_BITS'(($urandom_range(3) == 0) ? lo - 1 : $urandom_range(lo - 1, 0));
      if (hi < DUR_TOP)
         return NOM_BITS'(($urandom_range(3) == 0) ? hi + 1 : $urandom_range(DUR_TOP, hi + 1));
      return NOM_BITS'($urandom_range(DUR_TOP, 0));
   endfunction

   // Offers one pair and returns once it has been transferred. Valid is left high,
   // so the next call either replaces the data or first drops valid while it idles,
   // always at a fresh falling edge.
   task automatic send_pair(input logic start, input logic [NOM_BITS-1:0] mark,
                            input logic [NOM_BITS-1:0] space);
      @(negedge clock);
      while (!calm_mode && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= start;
      req_tdata  <= {space, mark};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_bit(input logic value);
      send_pair(1'b0, pick_inside(cfg_bit_mark),
                pick_inside(value ? cfg_one_space : cfg_zero_space));
   endtask

   // Random pairs over the full range; most carry no frame start and are ignored
   // when no frame is open, the rest are headers that almost never match.
   task automatic send_noise(input int count);
      logic start;
      for (int n = 0; n < count; n++) begin
         start = ($urandom_range(9) == 0);
         if (start) counted_items++;
         send_pair(start, NOM_BITS'($urandom), NOM_BITS'($urandom));
      end
   endtask

   // One frame with random content. A flaw, if any, is placed at a random spot;
   // after a failed or finished frame up to two stray pairs follow, ignored unless they carry a start.
   task automatic send_frame(input frame_flaw_type flaw);
      logic [DATA_BITS-1:0] payload;
      int                   cut_at;
      logic                 mark_bad;
      payload = '0;
      payload[11:0]  = 12'($urandom);
      payload[23:20] = 4'($urandom);
      payload[DATA_BITS-1 -: 11] = CONTROL_WORD;
      if (flaw == FLAW_CONTROL)
         payload[DATA_BITS-1 -: 11] = CONTROL_WORD ^ 11'($urandom_range(2047, 1));

      case (flaw)
         FLAW_NONE, FLAW_CONTROL: cut_at = DATA_BITS;
         FLAW_RESERVED: begin
            cut_at = $urandom_range(RSV_LAST, RSV_FIRST);
            payload[cut_at] = 1'b1;
         end
         default: cut_at = $urandom_range(DATA_BITS - 1, 0);
      endcase

      counted_items++;
      if (flaw == FLAW_HEADER) begin
         // Spoil the mark, the space or both.
         mark_bad = ($urandom_range(1) == 1);
         send_pair(1'b1, mark_bad ? pick_outside(cfg_hdr_mark) : pick_inside(cfg_hdr_mark),
                   (!mark_bad || $urandom_range(3) == 0) ? pick_outside(cfg_hdr_space)
                                                         : pick_inside(cfg_hdr_space));
         send_noise($urandom_range(2, 0));
         return;
      end
      send_pair(1'b1, pick_inside(cfg_hdr_mark), pick_inside(cfg_hdr_space));

      for (int k = 0; k < cut_at; k++)
         send_bit(payload[k]);
      counted_items += cut_at;

      // A cut frame is left open; the caller starts a new frame over it.
      if (flaw == FLAW_CUT) return;

      if (flaw == FLAW_PULSE) begin
         send_pair(1'b0, pick_outside(cfg_bit_mark),
                   pick_inside(payload[cut_at] ? cfg_one_space : cfg_zero_space));
         counted_items++;
      end else if (flaw == FLAW_RESERVED) begin
         send_bit(1'b1);
         counted_items++;
      end
      send_noise($urandom_range(2, 0));
   endtask

   // Mostly clean frames with random content, the rest broken frames and noise.
   task automatic send_random_traffic();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         send_frame(FLAW_NONE);
      end else if (pick < 62) begin
         send_frame(FLAW_HEADER);
      end else if (pick < 69) begin
         send_frame(FLAW_PULSE);
      end else if (pick < 76) begin
         send_frame(FLAW_RESERVED);
      end else if (pick < 83) begin
         send_frame(FLAW_CONTROL);
      end else if (pick < 92) begin
         send_frame(FLAW_CUT);
         send_frame(FLAW_NONE);
      end else begin
         send_noise($urandom_range(4, 1));
      end
   endtask

   // Holds the sender until every predicted result has been transferred, then
   // lets the pipeline run empty so that pairs with no result are done too.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frames_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [NOM_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         REG_HDR_MARK:   cfg_hdr_mark   = value;
         REG_HDR_SPACE:  cfg_hdr_space  = value;
         REG_BIT_MARK:   cfg_bit_mark   = value;
         REG_ONE_SPACE:  cfg_one_space  = value;
         REG_ZERO_SPACE: cfg_zero_space = value;
         REG_TOLERANCE:  cfg_tol        = value[TOL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all_nominals(input logic [NOM_BITS-1:0] hdr_mark,
                                     input logic [NOM_BITS-1:0] hdr_space,
                                     input logic [NOM_BITS-1:0] bit_mark,
                                     input logic [NOM_BITS-1:0] one_space,
                                     input logic [NOM_BITS-1:0] zero_space);
      write_reg(REG_HDR_MARK, hdr_mark);
      write_reg(REG_HDR_SPACE, hdr_space);
      write_reg(REG_BIT_MARK, bit_mark);
      write_reg(REG_ONE_SPACE, one_space);
      write_reg(REG_ZERO_SPACE, zero_space);
   endtask

   // Timing setting for each phase. Phase 0 keeps the values from reset.
   task automatic apply_phase(input int phase);
      case (phase)
         1: begin
            // Zero tolerance: only exact durations match. Spare indexes get junk.
            write_reg(REG_TOLERANCE, 16'd0);
            write_reg(SPARE_INDEX_LO, NOM_BITS'($urandom));
            write_reg(SPARE_INDEX_HI, 16'hFFFF);
         end
         2: write_reg(REG_TOLERANCE, 16'd100);
         3: begin
            // Upper data bits are dropped, leaving 127, which acts as 100.
            write_reg(REG_TOLERANCE, 16'hFF7F);
         end
         4: begin
            // All windows collapse onto zero; one and zero pulses coincide, so every
            // bit outside the reserved field reads as a one and the control word fails.
            write_all_nominals(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            write_reg(REG_TOLERANCE, 16'd50);
         end
         5: begin
            write_all_nominals(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            write_reg(REG_TOLERANCE, 16'd0);
         end
         6: begin
            // One and zero windows overlap in part; a pair in both counts as a one.
            write_all_nominals(16'd9000, 16'd4500, 16'd650, 16'd1200, 16'd1000);
            write_reg(REG_TOLERANCE, 16'd25);
         end
         default: begin
            write_all_nominals(NOM_BITS'($urandom_range(DUR_TOP, 2000)),
                               NOM_BITS'($urandom_range(30000, 1000)),
                               NOM_BITS'($urandom_range(2000, 100)),
                               NOM_BITS'($urandom_range(5000, 1500)),
                               NOM_BITS'($urandom_range(1000, 100)));
            write_reg(REG_TOLERANCE, NOM_BITS'($urandom_range(35, 0)));
         end
      endcase
      @(negedge clock);
      csr_we    <= 1'b0;
      calm_mode = (phase == CALM_PHASE);
   endtask

   // Short directed opening at the reset timing (header 9000/4500, bit mark 650,
   // one 1650, zero 550, tolerance 25 percent).
   task automatic send_directed();
      // Headers at the extremes of both fields fail.
      send_pair(1'b1, 16'd0, 16'd0);
      send_pair(1'b1, 16'hFFFF, 16'hFFFF);
      // With no frame open, pairs without a start flag are ignored.
      send_pair(1'b0, 16'hFFFF, 16'd0);
      send_pair(1'b0, 16'd0, 16'hFFFF);
      // Header one below the lower edge of the mark window.
      send_pair(1'b1, 16'd6749, 16'd4500);
      // Header on the window edges, then a zero bit on the lower edges.
      send_pair(1'b1, 16'd6750, 16'd5625);
      send_pair(1'b0, 16'd487, 16'd412);
      // A new start mid-frame drops the open frame without a result.
      send_pair(1'b1, 16'd11250, 16'd3375);
      // A space between the zero and one windows is a bad pulse.
      send_pair(1'b0, 16'd812, 16'd1100);
      // Twelve good bits, then a one pulse where the reserved zeros start.
      send_pair(1'b1, 16'd9000, 16'd4500);
      for (int k = 0; k < 12; k++)
         send_pair(1'b0, 16'd650, k[0] ? 16'd2062 : 16'd687);
      send_pair(1'b0, 16'd650, 16'd1650);
      // The frame has ended; this pair is ignored.
      send_pair(1'b0, 16'd650, 16'd550);
      counted_items += 21;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) begin
            send_directed();
         end else begin
            // The decoder must be idle before its timing changes.
            wait_idle();
            apply_phase(phase);
         end
         while (counted_items < (ITEM_TARGET * (phase + 1)) / PHASE_COUNT)
            send_random_traffic();
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
